@@ rtl/core/ssr_pkg.sv @@
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared widths, reset values and register indexes for the sphere screen
// rectangle pipeline.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam int COORD_W  = 32;   // signed view-space coordinate
   localparam int RAD_W    = 31;   // unsigned radius / near plane
   localparam int SCALE_W  = 24;   // projection scale
   localparam int PIX_W    = 14;   // pixel coordinate / screen size
   localparam int MAG_W    = 30;   // pre-scaled magnitude
   localparam int BIG_BIT  = 29;   // magnitudes at 2^29 or more are pre-scaled
   localparam int SQ_W     = 60;   // square / product width
   localparam int ROOT_W   = 30;   // square root width
   localparam int MN_W     = 61;   // tangent numerator / denominator magnitude

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_PLANE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_SCALE_X  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROJ_SCALE_Y  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd4;

   localparam logic [RAD_W-1:0]   NEAR_PLANE_RST    = 31'd6554;
   localparam logic [SCALE_W-1:0] PROJ_SCALE_RST    = 24'd65536;
   localparam logic [PIX_W-1:0]   SCREEN_WIDTH_RST  = 14'd1920;
   localparam logic [PIX_W-1:0]   SCREEN_HEIGHT_RST = 14'd1080;

endpackage

@@ rtl/core/ssr_sqrt.sv @@
// ----------------------------------------------------------------------------
// ssr_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module ssr_sqrt #(
   parameter int TAG_W = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic                       in_valid,
   input  logic [TAG_W-1:0]           in_tag,
   input  logic [ssr_pkg::SQ_W-1:0]   in_value,
   output logic                       out_valid,
   output logic [TAG_W-1:0]           out_tag,
   output logic [ssr_pkg::ROOT_W-1:0] out_root
);

   localparam int VW   = ssr_pkg::SQ_W;
   localparam int HALF = ssr_pkg::ROOT_W;

   logic [VW-1:0]    rem_ff [0:HALF-1];
   logic [VW:0]      res_ff [0:HALF-1];
   logic [TAG_W-1:0] tag_ff [0:HALF-1];
   logic             vld_ff [0:HALF-1];

   for (genvar k = 0; k < HALF; k++) begin : g_step
      localparam logic [VW:0] BITV = (VW+1)'(1) << (2*(HALF-1-k));
      logic [VW-1:0]    rem_i;
      logic [VW:0]      res_i;
      logic [TAG_W-1:0] tag_i;
      logic             vld_i;
      logic [VW:0]      trial;
      logic [VW-1:0]    rem_in;
      logic [VW:0]      res_in;

      if (k == 0) begin : g_first
         assign rem_i = in_value;
         assign res_i = '0;
         assign tag_i = in_tag;
         assign vld_i = in_valid;
      end else begin : g_next
         assign rem_i = rem_ff[k-1];
         assign res_i = res_ff[k-1];
         assign tag_i = tag_ff[k-1];
         assign vld_i = vld_ff[k-1];
      end

      always_comb begin
         trial = res_i + BITV;
         if ({1'b0, rem_i} >= trial) begin
            rem_in = rem_i - trial[VW-1:0];
            res_in = (res_i >> 1) + BITV;
         end else begin
            rem_in = rem_i;
            res_in = res_i >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            res_ff[k] <= res_in;
            tag_ff[k] <= tag_i;
         end
      end
   end

   assign out_valid = vld_ff[HALF-1];
   assign out_tag   = tag_ff[HALF-1];
   assign out_root  = res_ff[HALF-1][HALF-1:0];

endmodule

@@ rtl/core/ssr_div.sv @@
// ----------------------------------------------------------------------------
// ssr_div
// Pipelined saturating quotient floor(scale * num / den), limited to one.
// ----------------------------------------------------------------------------
module ssr_div #(
   parameter int FRAC_BITS = ssr_pkg::FRAC_BITS_DEF,
   parameter int TAG_W     = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [TAG_W-1:0]            in_tag,
   input  logic [ssr_pkg::SCALE_W-1:0] in_scale,
   input  logic [ssr_pkg::MN_W-1:0]    in_num,
   input  logic [ssr_pkg::MN_W-1:0]    in_den,
   output logic                        out_valid,
   output logic [TAG_W-1:0]            out_tag,
   output logic [FRAC_BITS:0]          out_quot
);

   localparam int MW    = ssr_pkg::MN_W;
   localparam int SW    = ssr_pkg::SCALE_W;
   localparam int LO_W  = 31;
   localparam int HI_W  = MW - LO_W;
   localparam int NSTEP = FRAC_BITS + 2;
   localparam int XW    = SW + MW;
   localparam int RW    = (MW + NSTEP > XW) ? MW + NSTEP : XW;
   localparam logic [NSTEP-1:0] ONE_Q = NSTEP'(1) << FRAC_BITS;

   // partial products
   logic [SW+LO_W-1:0] pp_lo_ff;
   logic [SW+HI_W-1:0] pp_hi_ff;
   logic [MW-1:0]      den1_ff;
   logic [TAG_W-1:0]   tag1_ff;
   logic               vld1_ff;

   logic [RW-1:0]    rem_ff  [0:NSTEP];
   logic [MW-1:0]    den_ff  [0:NSTEP];
   logic [NSTEP-1:0] quot_ff [0:NSTEP];
   logic             sat_ff  [0:NSTEP];
   logic [TAG_W-1:0] tag_ff  [0:NSTEP];
   logic             vld_ff  [0:NSTEP];

   logic [RW-1:0] x_in;
   logic          sat_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_lo_ff <= in_scale * in_num[LO_W-1:0];
         pp_hi_ff <= in_scale * in_num[MW-1:LO_W];
         den1_ff  <= in_den;
         tag1_ff  <= in_tag;
      end
   end

   always_comb begin
      x_in   = (RW'(pp_hi_ff) << LO_W) + RW'(pp_lo_ff);
      sat_in = x_in >= (RW'(den1_ff) << NSTEP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= x_in;
         den_ff[0]  <= den1_ff;
         quot_ff[0] <= '0;
         sat_ff[0]  <= sat_in;
         tag_ff[0]  <= tag1_ff;
      end
   end

   for (genvar j = 0; j < NSTEP; j++) begin : g_step
      localparam int SH = NSTEP - 1 - j;
      logic [RW-1:0]    dsh;
      logic [RW-1:0]    rem_in;
      logic [NSTEP-1:0] quot_in;

      always_comb begin
         dsh     = RW'(den_ff[j]) << SH;
         rem_in  = rem_ff[j];
         quot_in = quot_ff[j];
         if (rem_ff[j] >= dsh) begin
            rem_in      = rem_ff[j] - dsh;
            quot_in[SH] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else if (en) begin
            vld_ff[j+1] <= vld_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= rem_in;
            den_ff[j+1]  <= den_ff[j];
            quot_ff[j+1] <= quot_in;
            sat_ff[j+1]  <= sat_ff[j];
            tag_ff[j+1]  <= tag_ff[j];
         end
      end
   end

   assign out_valid = vld_ff[NSTEP];
   assign out_tag   = tag_ff[NSTEP];
   assign out_quot  = (sat_ff[NSTEP] || quot_ff[NSTEP] > ONE_Q) ? ONE_Q[FRAC_BITS:0]
                                                                : quot_ff[NSTEP][FRAC_BITS:0];

endmodule

@@ rtl/core/ssr_axis.sv @@
// ----------------------------------------------------------------------------
// ssr_axis
// One screen axis: tangent planes of the sphere through the eye, narrowed
// clip interval [lo, hi] in signed fixed point.
// ----------------------------------------------------------------------------
module ssr_axis #(
   parameter int FRAC_BITS = ssr_pkg::FRAC_BITS_DEF,
   parameter int TAG_W     = 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               en,
   input  logic                               in_valid,
   input  logic [TAG_W-1:0]                   in_tag,
   input  logic signed [ssr_pkg::COORD_W-1:0] in_coord,
   input  logic signed [ssr_pkg::COORD_W-1:0] in_z,
   input  logic [ssr_pkg::RAD_W-1:0]          in_radius,
   input  logic [ssr_pkg::SCALE_W-1:0]        in_scale,
   output logic                               out_valid,
   output logic [TAG_W-1:0]                   out_tag,
   output logic signed [FRAC_BITS+1:0]        out_lo,
   output logic signed [FRAC_BITS+1:0]        out_hi
);

   localparam int CW  = ssr_pkg::COORD_W;
   localparam int AW  = ssr_pkg::MAG_W;
   localparam int SW  = ssr_pkg::SCALE_W;
   localparam int QW  = ssr_pkg::SQ_W;
   localparam int DW  = ssr_pkg::ROOT_W;
   localparam int MW  = ssr_pkg::MN_W;
   localparam int VW  = FRAC_BITS + 2;
   localparam int ST_W = 3 + 3*AW + SW + TAG_W;
   localparam int RT_W = 3 + TAG_W;
   localparam logic signed [VW-1:0] ONE_S  = VW'(1) << FRAC_BITS;
   localparam logic signed [VW-1:0] MONE_S = -ONE_S;

   // stage A1: magnitudes, pre-scaled
   logic [CW-1:0]    ac_w, az_w;
   logic             big_w;
   logic [AW-1:0]    ac1_ff, az1_ff, r1_ff;
   logic [SW-1:0]    s1_ff;
   logic             cneg1_ff, zneg1_ff, vld1_ff;
   logic [TAG_W-1:0] tag1_ff;

   always_comb begin
      ac_w  = in_coord[CW-1] ? CW'(-in_coord) : in_coord;
      az_w  = in_z[CW-1] ? CW'(-in_z) : in_z;
      big_w = (ac_w >= (CW'(1) << ssr_pkg::BIG_BIT)) || (az_w >= (CW'(1) << ssr_pkg::BIG_BIT))
              || (CW'(in_radius) >= (CW'(1) << ssr_pkg::BIG_BIT));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ac1_ff   <= big_w ? ac_w[AW+1:2] : ac_w[AW-1:0];
         az1_ff   <= big_w ? az_w[AW+1:2] : az_w[AW-1:0];
         r1_ff    <= big_w ? AW'(in_radius >> 2) : in_radius[AW-1:0];
         s1_ff    <= in_scale;
         cneg1_ff <= in_coord[CW-1];
         zneg1_ff <= in_z[CW-1];
         tag1_ff  <= in_tag;
      end
   end

   // stage A2: squares
   logic [QW-1:0]    sqc2_ff, sqz2_ff, sqr2_ff;
   logic [AW-1:0]    ac2_ff, az2_ff, r2_ff;
   logic [SW-1:0]    s2_ff;
   logic             cneg2_ff, zneg2_ff, vld2_ff;
   logic [TAG_W-1:0] tag2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         sqc2_ff  <= ac1_ff * ac1_ff;
         sqz2_ff  <= az1_ff * az1_ff;
         sqr2_ff  <= r1_ff * r1_ff;
         ac2_ff   <= ac1_ff;
         az2_ff   <= az1_ff;
         r2_ff    <= r1_ff;
         s2_ff    <= s1_ff;
         cneg2_ff <= cneg1_ff;
         zneg2_ff <= zneg1_ff;
         tag2_ff  <= tag1_ff;
      end
   end

   // stage A3: discriminant
   logic [QW:0]      l2_w;
   logic [QW-1:0]    v3_ff;
   logic [ST_W-1:0]  st3_ff;
   logic             vld3_ff;

   assign l2_w = {1'b0, sqc2_ff} + {1'b0, sqz2_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         v3_ff  <= QW'(l2_w - {1'b0, sqr2_ff});
         st3_ff <= {(az2_ff == '0) || (l2_w < {1'b0, sqr2_ff}), cneg2_ff, zneg2_ff,
                    ac2_ff, az2_ff, r2_ff, s2_ff, tag2_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (en) begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
   end

   logic            sq_vld;
   logic [ST_W-1:0] sq_st;
   logic [DW-1:0]   sq_d;

   ssr_sqrt #(
      .TAG_W(ST_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (vld3_ff),
      .in_tag   (st3_ff),
      .in_value (v3_ff),
      .out_valid(sq_vld),
      .out_tag  (sq_st),
      .out_root (sq_d)
   );

   // stage B1: products
   logic             skip_w, cneg_w, zneg_w;
   logic [AW-1:0]    ac_s, az_s, r_s;
   logic [SW-1:0]    s_s;
   logic [TAG_W-1:0] tag_s;

   assign {skip_w, cneg_w, zneg_w, ac_s, az_s, r_s, s_s, tag_s} = sq_st;

   logic [QW-1:0]    p1_ff, p2_ff, p3_ff, p4_ff;
   logic             skip4_ff, cneg4_ff, zneg4_ff, vld4_ff;
   logic [SW-1:0]    s4_ff;
   logic [TAG_W-1:0] tag4_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff    <= r_s * ac_s;
         p2_ff    <= QW'(az_s * sq_d);
         p3_ff    <= QW'(sq_d * ac_s);
         p4_ff    <= r_s * az_s;
         skip4_ff <= skip_w || (sq_d == '0);
         cneg4_ff <= cneg_w;
         zneg4_ff <= zneg_w;
         s4_ff    <= s_s;
         tag4_ff  <= tag_s;
      end
   end

   // stage B2: numerators, denominators, root selection
   logic signed [QW+1:0] p1s, p2s, p3s, p4s, rc, dc, np, nm, mp, mm;
   logic                 ok0, ok1, neg0, neg1;

   always_comb begin
      p1s  = $signed({2'b00, p1_ff});
      p2s  = $signed({2'b00, p2_ff});
      p3s  = $signed({2'b00, p3_ff});
      p4s  = $signed({2'b00, p4_ff});
      rc   = cneg4_ff ? -p1s : p1s;
      dc   = cneg4_ff ? -p3s : p3s;
      np   = rc + p2s;
      nm   = rc - p2s;
      mp   = dc - p4s;
      mm   = -dc - p4s;
      ok0  = !skip4_ff && (np != '0) && (zneg4_ff ^ np[QW+1]);
      ok1  = !skip4_ff && (nm != '0) && !(zneg4_ff ^ nm[QW+1]);
      neg0 = zneg4_ff ^ mp[QW+1] ^ np[QW+1];
      neg1 = zneg4_ff ^ mm[QW+1] ^ nm[QW+1];
   end

   logic [MW-1:0]    num0_ff, den0_ff, num1_ff, den1_ff;
   logic [SW-1:0]    s5_ff;
   logic [RT_W-1:0]  rt0_ff;
   logic [2:0]       rt1_ff;
   logic             vld5_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         num0_ff <= mp[QW+1] ? MW'(-mp) : MW'(mp);
         den0_ff <= np[QW+1] ? MW'(-np) : MW'(np);
         num1_ff <= mm[QW+1] ? MW'(-mm) : MW'(mm);
         den1_ff <= nm[QW+1] ? MW'(-nm) : MW'(nm);
         s5_ff   <= s4_ff;
         rt0_ff  <= {ok0, neg0, np[QW+1], tag4_ff};
         rt1_ff  <= {ok1, neg1, nm[QW+1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else if (en) begin
         vld4_ff <= sq_vld;
         vld5_ff <= vld4_ff;
      end
   end

   logic                 dv0, dv1;
   logic [RT_W-1:0]      dt0;
   logic [2:0]           dt1;
   logic [FRAC_BITS:0]   q0, q1;

   ssr_div #(
      .FRAC_BITS(FRAC_BITS),
      .TAG_W    (RT_W)
   ) u_div0 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (vld5_ff),
      .in_tag   (rt0_ff),
      .in_scale (s5_ff),
      .in_num   (num0_ff),
      .in_den   (den0_ff),
      .out_valid(dv0),
      .out_tag  (dt0),
      .out_quot (q0)
   );

   ssr_div #(
      .FRAC_BITS(FRAC_BITS),
      .TAG_W    (3)
   ) u_div1 (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (vld5_ff),
      .in_tag   (rt1_ff),
      .in_scale (s5_ff),
      .in_num   (num1_ff),
      .in_den   (den1_ff),
      .out_valid(dv1),
      .out_tag  (dt1),
      .out_quot (q1)
   );

   // stage C1: narrow the interval
   logic signed [VW-1:0] val0, val1, lo_in, hi_in;

   always_comb begin
      val0  = dt0[RT_W-2] ? -$signed({1'b0, q0}) : $signed({1'b0, q0});
      val1  = dt1[1] ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
      lo_in = MONE_S;
      hi_in = ONE_S;
      if (dt0[RT_W-1]) begin
         if (dt0[RT_W-3]) begin
            if (val0 > lo_in) lo_in = val0;
         end else begin
            if (val0 < hi_in) hi_in = val0;
         end
      end
      if (dt1[2]) begin
         if (dt1[0]) begin
            if (val1 > lo_in) lo_in = val1;
         end else begin
            if (val1 < hi_in) hi_in = val1;
         end
      end
   end

   logic signed [VW-1:0] lo_ff, hi_ff;
   logic [TAG_W-1:0]     tag6_ff;
   logic                 vld6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
      end else if (en) begin
         vld6_ff <= dv0 & dv1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         tag6_ff <= dt0[TAG_W-1:0];
      end
   end

   assign out_valid = vld6_ff;
   assign out_tag   = tag6_ff;
   assign out_lo    = lo_ff;
   assign out_hi    = hi_ff;

endmodule

@@ rtl/core/sphere_screen_rect.sv @@
// ----------------------------------------------------------------------------
// sphere_screen_rect
// Pixel bounding rectangle and visible flag of a view-space light sphere.
// Throughput: one sphere per cycle while req_tready is high; the
// square root (one bit per stage) and the divider (one quotient bit per
// stage) set the depth.
// A one-entry skid slot behind the output register holds a result while the
// rsp side stalls; req_tready drops while that slot is full.
// Reset is synchronous: it clears all valid bits and loads the register
// reset values.
// ----------------------------------------------------------------------------
module sphere_screen_rect #(
   parameter int FRAC_BITS = ssr_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [127:0]                   req_tdata,   // center_x, center_y, center_z,
                                                       // sphere_radius, pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [55:0]                    rsp_tdata,   // rect_min_x, rect_min_y,
                                                       // rect_max_x, rect_max_y
   output logic                           rsp_tuser,   // visible
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ssr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssr_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CW = ssr_pkg::COORD_W;
   localparam int RW = ssr_pkg::RAD_W;
   localparam int SW = ssr_pkg::SCALE_W;
   localparam int PW = ssr_pkg::PIX_W;
   localparam int VW = FRAC_BITS + 2;
   localparam logic signed [VW-1:0] ONE_S = VW'(1) << FRAC_BITS;

   // configuration
   logic [RW-1:0] near_ff;
   logic [SW-1:0] scx_ff, scy_ff;
   logic [PW-1:0] sw_ff, sh_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         near_ff <= ssr_pkg::NEAR_PLANE_RST;
         scx_ff  <= ssr_pkg::PROJ_SCALE_RST;
         scy_ff  <= ssr_pkg::PROJ_SCALE_RST;
         sw_ff   <= ssr_pkg::SCREEN_WIDTH_RST;
         sh_ff   <= ssr_pkg::SCREEN_HEIGHT_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            ssr_pkg::CSR_NEAR_PLANE:    near_ff <= csr_data[RW-1:0];
            ssr_pkg::CSR_PROJ_SCALE_X:  scx_ff  <= csr_data[SW-1:0];
            ssr_pkg::CSR_PROJ_SCALE_Y:  scy_ff  <= csr_data[SW-1:0];
            ssr_pkg::CSR_SCREEN_WIDTH:  sw_ff   <= csr_data[PW-1:0];
            ssr_pkg::CSR_SCREEN_HEIGHT: sh_ff   <= csr_data[PW-1:0];
            default: ;
         endcase
      end
   end

   // input unpack and near plane test
   logic signed [CW-1:0] cx, cy, cz;
   logic [RW-1:0]        rad;
   logic signed [CW+1:0] near_sum;
   logic                 front;
   logic                 en;
   logic                 skid_v_ff;

   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_comb begin
      cx       = $signed(req_tdata[CW-1:0]);
      cy       = $signed(req_tdata[2*CW-1:CW]);
      cz       = $signed(req_tdata[3*CW-1:2*CW]);
      rad      = req_tdata[3*CW+RW-1:3*CW];
      near_sum = {{2{cz[CW-1]}}, cz} - $signed({3'b000, rad}) + $signed({3'b000, near_ff});
      front    = near_sum[CW+1] || (near_sum == '0);
   end

   logic                 xv, yv, xt, yt;
   logic signed [VW-1:0] lox, hix, loy, hiy;

   ssr_axis #(
      .FRAC_BITS(FRAC_BITS),
      .TAG_W    (1)
   ) u_axis_x (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_tag   (front),
      .in_coord (cx),
      .in_z     (cz),
      .in_radius(rad),
      .in_scale (scx_ff),
      .out_valid(xv),
      .out_tag  (xt),
      .out_lo   (lox),
      .out_hi   (hix)
   );

   ssr_axis #(
      .FRAC_BITS(FRAC_BITS),
      .TAG_W    (1)
   ) u_axis_y (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_tag   (front),
      .in_coord (cy),
      .in_z     (cz),
      .in_radius(rad),
      .in_scale (scy_ff),
      .out_valid(yv),
      .out_tag  (yt),
      .out_lo   (loy),
      .out_hi   (hiy)
   );

   // pixel mapping
   function automatic logic [PW-1:0] to_pix(logic signed [VW-1:0] clip,
                                            logic [PW-1:0] size);
      logic signed [VW:0] diff;
      logic [VW+PW-1:0]   prod;
      begin
         diff   = $signed({ONE_S[VW-1], ONE_S}) - $signed({clip[VW-1], clip});
         prod   = diff[VW-1:0] * size;
         to_pix = prod[FRAC_BITS+1 +: PW];
      end
   endfunction

   logic [PW-1:0] mnx_ff, mxx_ff, mny_ff, mxy_ff;
   logic          front_p_ff, vld_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p_ff <= 1'b0;
      end else if (en) begin
         vld_p_ff <= xv & yv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mnx_ff     <= to_pix(hix, sw_ff);
         mxx_ff     <= to_pix(lox, sw_ff);
         mny_ff     <= to_pix(hiy, sh_ff);
         mxy_ff     <= to_pix(loy, sh_ff);
         front_p_ff <= xt & yt;
      end
   end

   // output register and skid slot
   logic          vis_w;
   logic [55:0]   data_w;
   logic          out_v_ff, out_v_in, skid_v_in;
   logic [56:0]   out_d_ff, out_d_in, skid_d_ff, skid_d_in;
   logic          take;

   assign vis_w  = front_p_ff && (mnx_ff < mxx_ff) && (mny_ff < mxy_ff);
   assign data_w = vis_w ? {mxy_ff, mxx_ff, mny_ff, mnx_ff} : '0;
   assign take   = out_v_ff & rsp_tready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (take) out_v_in = 1'b0;
      if (skid_v_ff && take) begin
         out_v_in  = 1'b1;
         out_d_in  = skid_d_ff;
         skid_v_in = 1'b0;
      end else if (vld_p_ff && en) begin
         if (!out_v_ff || take) begin
            out_v_in = 1'b1;
            out_d_in = {vis_w, data_w};
         end else begin
            skid_v_in = 1'b1;
            skid_d_in = {vis_w, data_w};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_d_ff[55:0];
   assign rsp_tuser  = out_d_ff[56];

endmodule

@@ rtl/core/ssr_check.sv @@
// ----------------------------------------------------------------------------
// ssr_check
// Port-level checks for sphere_screen_rect, bound to the top level.
// ----------------------------------------------------------------------------
module ssr_check (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [127:0]                   req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [55:0]                    rsp_tdata,
   input logic                           rsp_tuser,
   input logic                           csr_valid,
   input logic                           csr_ready,
   input logic [ssr_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [ssr_pkg::CSR_DATA_W-1:0] csr_data
);

   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   a_hidden_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 56'd0)
      else $error("hidden result with nonzero rectangle");

   a_rect_order : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[13:0] < rsp_tdata[41:28]) &&
                                  (rsp_tdata[27:14] < rsp_tdata[55:42]))
      else $error("visible rectangle with min not below max");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind sphere_screen_rect ssr_check u_ssr_check (.*);
